// ----- rtl/bsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types, stage numbering and helpers for the pressure/temperature
// compensation pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int AddrW = 5;
  localparam int DataW = 64;

  // register indexes
  localparam logic [1:0] REG_CAL_A = 2'd0;
  localparam logic [1:0] REG_CAL_B = 2'd1;
  localparam logic [1:0] REG_CAL_M = 2'd2;
  localparam logic [1:0] REG_OSS   = 2'd3;

  // temperature divide: 27-bit dividend magnitude
  localparam int TdBits = 27;
  // pressure divide: 32-bit dividend
  localparam int PdBits = 32;

  localparam int S_IN    = 0;
  localparam int S_X1    = 1;
  localparam int S_TSET  = 2;
  localparam int S_TD0   = 3;
  localparam int S_B5    = S_TD0 + TdBits;
  localparam int S_MUL1  = S_B5 + 1;
  localparam int S_MUL2  = S_MUL1 + 1;
  localparam int S_B3    = S_MUL2 + 1;
  localparam int S_B4    = S_B3 + 1;
  localparam int S_B7    = S_B4 + 1;
  localparam int S_PSET  = S_B7 + 1;
  localparam int S_PD0   = S_PSET + 1;
  localparam int S_P     = S_PD0 + PdBits;
  localparam int S_X1P   = S_P + 1;
  localparam int S_OUT   = S_X1P + 1;
  localparam int NumStg  = S_OUT + 1;

  localparam logic [31:0] B6Off   = 32'd4000;
  localparam logic [31:0] B4Off   = 32'd32768;
  localparam logic [31:0] OssBase = 32'd50000;
  localparam logic [31:0] KP1     = 32'd3038;
  localparam logic [31:0] KP2     = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] KP3     = 32'd3791;

  typedef struct packed {
    logic        vld;
    logic        err;
    logic        neg;
    logic        sh;
    logic [15:0] ut;
    logic [18:0] up;
    logic [31:0] x1;
    logic [31:0] x2;
    logic [31:0] t;
    logic [31:0] b6;
    logic [31:0] sq;
    logic [31:0] m2;
    logic [31:0] m3;
    logic [31:0] p1;
    logic [31:0] p2;
    logic [31:0] b3;
    logic [31:0] s;
    logic [31:0] b4;
    logic [31:0] b7;
    logic [31:0] p;
    logic [32:0] rem;
    logic [31:0] quo;
    logic [31:0] dvs;
  } ctx_t;

  function automatic logic [31:0] asr(input logic [31:0] v, input int n);
    asr = 32'($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  // one restoring divide step; top selects the next dividend bit
  function automatic ctx_t div_step(input ctx_t c, input logic [4:0] top);
    ctx_t        o;
    logic [32:0] r;
    o = c;
    r = {c.rem[31:0], c.quo[top]};
    o.quo = c.quo << 1;
    if (r >= {1'b0, c.dvs}) begin
      o.rem    = r - {1'b0, c.dvs};
      o.quo[0] = 1'b1;
    end else begin
      o.rem = r;
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/baro_sensor_compensation_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// baro_sensor_compensation_core
// Barometric temperature/pressure compensation, fully pipelined.
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_*       in   tdata: raw_temperature, raw_pressure
// m_*       out  tdata: temperature, pressure; tuser: divide_error
// apb       in   cal_word_a, cal_word_b, cal_word_m, oversampling
//
// One item per cycle while the output is not stalled; the two bit-per-stage
// dividers take 27 stages (temperature) and 32 stages (pressure).
// Reset clears the stage valid bits and the calibration registers.
// A stall at the output freezes every stage; s_tready follows it.
module baro_sensor_compensation_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [39:0] s_tdata,   // raw_temperature[15:0], raw_pressure[34:16]
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [63:0] m_tdata,   // temperature[31:0], pressure[63:32]
  output      logic [0:0]  m_tuser,   // divide_error
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [bsc_pkg::AddrW-1:0] paddr,
  input  wire logic [bsc_pkg::DataW-1:0] pwdata,
  output      logic [bsc_pkg::DataW-1:0] prdata,
  output      logic        pready
);

  logic [63:0] cal_a;
  logic [63:0] cal_b;
  logic [31:0] cal_m;
  logic [1:0]  oss;

  bsc_pkg::ctx_t st [bsc_pkg::NumStg];
  bsc_pkg::ctx_t nx [bsc_pkg::NumStg];
  logic          en;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_a <= '0;
      cal_b <= '0;
      cal_m <= '0;
      oss   <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:3])
        bsc_pkg::REG_CAL_A: cal_a <= pwdata;
        bsc_pkg::REG_CAL_B: cal_b <= pwdata;
        bsc_pkg::REG_CAL_M: cal_m <= pwdata[31:0];
        bsc_pkg::REG_OSS:   oss   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      bsc_pkg::REG_CAL_A: prdata = cal_a;
      bsc_pkg::REG_CAL_B: prdata = cal_b;
      bsc_pkg::REG_CAL_M: prdata = {32'd0, cal_m};
      bsc_pkg::REG_OSS:   prdata = {62'd0, oss};
      default:            prdata = '0;
    endcase
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = bsc_pkg::sx16(cal_a[63:48]);
  assign ac2 = bsc_pkg::sx16(cal_a[47:32]);
  assign ac3 = bsc_pkg::sx16(cal_a[31:16]);
  assign ac4 = {16'd0, cal_a[15:0]};
  assign ac5 = {16'd0, cal_b[63:48]};
  assign ac6 = {16'd0, cal_b[47:32]};
  assign b1  = bsc_pkg::sx16(cal_b[31:16]);
  assign b2  = bsc_pkg::sx16(cal_b[15:0]);
  assign mc  = bsc_pkg::sx16(cal_m[31:16]);
  assign md  = bsc_pkg::sx16(cal_m[15:0]);

  assign m_tvalid = st[bsc_pkg::NumStg-1].vld;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tdata  = {st[bsc_pkg::NumStg-1].p, st[bsc_pkg::NumStg-1].t};
  assign m_tuser  = st[bsc_pkg::NumStg-1].err;

  always_comb begin
    bsc_pkg::ctx_t c;
    logic [31:0]   den;
    logic [31:0]   num;
    logic [31:0]   tmp;
    for (int i = 0; i < bsc_pkg::NumStg; i++) begin
      if (i == 0) begin
        c     = '0;
        c.vld = s_tvalid;
        c.ut  = s_tdata[15:0];
        c.up  = s_tdata[34:16];
      end else begin
        c = st[i-1];
      end
      den = '0;
      num = '0;
      tmp = '0;
      if (i >= bsc_pkg::S_TD0 && i < bsc_pkg::S_TD0 + bsc_pkg::TdBits) begin
        c = bsc_pkg::div_step(c, 5'(bsc_pkg::TdBits - 1));
      end else if (i >= bsc_pkg::S_PD0 && i < bsc_pkg::S_PD0 + bsc_pkg::PdBits) begin
        c = bsc_pkg::div_step(c, 5'(bsc_pkg::PdBits - 1));
      end else begin
        case (i)
          bsc_pkg::S_X1: begin
            tmp  = ({16'd0, c.ut} - ac6) * ac5;
            c.x1 = bsc_pkg::asr(tmp, 15);
          end
          bsc_pkg::S_TSET: begin
            den   = c.x1 + md;
            num   = mc << 11;
            c.err = (den == '0);
            c.neg = num[31] ^ den[31];
            c.quo = num[31] ? -num : num;
            c.dvs = den[31] ? -den : den;
            c.rem = '0;
          end
          bsc_pkg::S_B5: begin
            tmp  = c.x1 + (c.neg ? -c.quo : c.quo);
            c.t  = bsc_pkg::asr(tmp + 32'd8, 4);
            c.b6 = tmp - bsc_pkg::B6Off;
          end
          bsc_pkg::S_MUL1: begin
            c.sq = c.b6 * c.b6;
            c.m2 = ac2 * c.b6;
            c.m3 = ac3 * c.b6;
          end
          bsc_pkg::S_MUL2: begin
            tmp  = bsc_pkg::asr(c.sq, 12);
            c.p1 = tmp * b2;
            c.p2 = tmp * b1;
            c.m2 = bsc_pkg::asr(c.m2, 11);
            c.m3 = bsc_pkg::asr(c.m3, 13);
          end
          bsc_pkg::S_B3: begin
            tmp  = ((ac1 << 2) + bsc_pkg::asr(c.p1, 11) + c.m2) << oss;
            c.b3 = bsc_pkg::asr(tmp + 32'd2, 2);
            tmp  = bsc_pkg::asr(c.m3 + bsc_pkg::asr(c.p2, 16) + 32'd2, 2);
            c.s  = tmp + bsc_pkg::B4Off;
          end
          bsc_pkg::S_B4: begin
            tmp  = c.s * ac4;
            c.b4 = {15'd0, tmp[31:15]};
            c.b7 = {13'd0, c.up} - c.b3;
          end
          bsc_pkg::S_B7: begin
            c.b7  = c.b7 * (bsc_pkg::OssBase >> oss);
            c.err = c.err || (c.b4 == '0);
          end
          bsc_pkg::S_PSET: begin
            c.sh  = c.b7[31];
            c.quo = c.b7[31] ? c.b7 : (c.b7 << 1);
            c.dvs = c.b4;
            c.rem = '0;
          end
          bsc_pkg::S_P: begin
            c.p  = c.sh ? (c.quo << 1) : c.quo;
            tmp  = bsc_pkg::asr(c.p, 8);
            c.sq = tmp * tmp;
            tmp  = c.p * bsc_pkg::KP2;
            c.x2 = bsc_pkg::asr(tmp, 16);
          end
          bsc_pkg::S_X1P: begin
            tmp  = c.sq * bsc_pkg::KP1;
            c.x1 = bsc_pkg::asr(tmp, 16);
          end
          bsc_pkg::S_OUT: begin
            c.p = c.p + bsc_pkg::asr(c.x1 + c.x2 + bsc_pkg::KP3, 4);
            if (c.err) begin
              c.p = '0;
              c.t = '0;
            end
          end
          default: ;
        endcase
      end
      nx[i] = c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bsc_pkg::NumStg; i++) begin
        st[i].vld <= 1'b0;
      end
    end else if (en) begin
      for (int i = 0; i < bsc_pkg::NumStg; i++) begin
        st[i] <= nx[i];
      end
    end
  end

endmodule
`default_nettype wire

// ----- test/baro_sensor_compensation_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_sensor_compensation_checker
// Watches the input and output streams and the register port of the
// compensation core. It computes the expected temperature, pressure and divide
// error for every accepted reading and compares them with the results in order.
// ----------------------------------------------------------------------------
module baro_sensor_compensation_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [39:0] s_tdata,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [63:0] m_tdata,
  input  wire logic [0:0]  m_tuser,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [bsc_pkg::AddrW-1:0] paddr,
  input  wire logic [bsc_pkg::DataW-1:0] pwdata,
  output int               errors,
  output int               pending
);

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] pres;
    logic        derr;
  } reading_t;

  logic [63:0] cal_a, cal_b;
  logic [31:0] cal_m;
  logic [1:0]  oss;
  reading_t    readings_due[$];

  function automatic logic signed [31:0] sra(input logic signed [31:0] v, input int n);
    return v >>> n;
  endfunction

  function automatic reading_t compensate(input logic [15:0] ut, input logic [18:0] up);
    reading_t r;
    logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md, ac4, ac5, ac6;
    logic signed [31:0] x1, x2, x3, den, b5, t, b6, b3, p;
    logic [31:0] b4, b7, pu;
    ac1 = 32'(signed'(cal_a[63:48])); ac2 = 32'(signed'(cal_a[47:32]));
    ac3 = 32'(signed'(cal_a[31:16])); ac4 = {16'd0, cal_a[15:0]};
    ac5 = {16'd0, cal_b[63:48]}; ac6 = {16'd0, cal_b[47:32]};
    b1 = 32'(signed'(cal_b[31:16])); b2 = 32'(signed'(cal_b[15:0]));
    mc = 32'(signed'(cal_m[31:16])); md = 32'(signed'(cal_m[15:0]));
    r = '0;
    r.derr = 1'b1;
    x1 = sra(({16'd0, ut} - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) return r;
    x2 = (mc * 2048) / den;
    b5 = x1 + x2;
    t = sra(b5 + 8, 4);
    b6 = b5 - 4000;
    x1 = sra(sra(b6 * b6, 12) * b2, 11);
    x2 = sra(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = (ac1 * 4 + x3) << oss;
    b3 = sra(b3 + 2, 2);
    x1 = sra(ac3 * b6, 13);
    x2 = sra(sra(b6 * b6, 12) * b1, 16);
    x3 = sra(x1 + x2 + 2, 2);
    b4 = ((x3 + 32768) * ac4) >> 15;
    if (b4 == 0) return r;
    b7 = ({13'd0, up} - b3) * (32'd50000 >> oss);
    if (!b7[31]) pu = (b7 << 1) / b4;
    else pu = (b7 / b4) << 1;
    p = pu;
    x1 = sra(p, 8);
    x1 = x1 * x1;
    x1 = sra(x1 * 3038, 16);
    x2 = sra(p * -7357, 16);
    p = p + sra(x1 + x2 + 3791, 4);
    r.temp = t;
    r.pres = p;
    r.derr = 1'b0;
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  always @(posedge clk) begin
    reading_t w;
    if (rst) begin
      cal_a <= '0; cal_b <= '0; cal_m <= '0; oss <= '0;
      errors = 0;
      readings_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:3])
          bsc_pkg::REG_CAL_A: cal_a <= pwdata;
          bsc_pkg::REG_CAL_B: cal_b <= pwdata;
          bsc_pkg::REG_CAL_M: cal_m <= pwdata[31:0];
          bsc_pkg::REG_OSS:   oss <= pwdata[1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        readings_due.push_back(compensate(s_tdata[15:0], s_tdata[34:16]));
      if (m_tvalid && m_tready) begin
        if (readings_due.size() == 0) begin
          report("unexpected item", m_tdata[31:0], 32'd0);
        end else begin
          w = readings_due.pop_front();
          if (m_tdata[31:0] !== w.temp) report("temperature", m_tdata[31:0], w.temp);
          if (m_tdata[63:32] !== w.pres) report("pressure", m_tdata[63:32], w.pres);
          if (m_tuser[0] !== w.derr) report("divide_error", 32'(m_tuser), 32'(w.derr));
        end
      end
    end
    pending = readings_due.size();
  end
endmodule

// ----- test/baro_sensor_compensation_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_sensor_compensation_core_tb
// Drives readings through the compensation core under several calibration
// sets and oversampling settings, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module baro_sensor_compensation_core_tb;

  localparam int Limit = 5000;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0, m_tready = 0;
  logic [39:0] s_tdata = '0;
  logic s_tready, m_tvalid;
  logic [63:0] m_tdata;
  logic [0:0] m_tuser;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [bsc_pkg::AddrW-1:0] paddr = '0;
  logic [bsc_pkg::DataW-1:0] pwdata = '0;
  logic [bsc_pkg::DataW-1:0] prdata;
  logic pready;
  int errors, pending, idle_cycles;
  bit sink_stall_on = 1;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  baro_sensor_compensation_core i_dut (.*);

  baro_sensor_compensation_checker i_chk (.*);

  // standard-like calibration set
  localparam logic [63:0] NomA = {16'd408, -16'sd72, -16'sd14383, 16'd32741};
  localparam logic [63:0] NomB = {16'd32757, 16'd23153, 16'd6190, 16'd4};
  localparam logic [31:0] NomM = {-16'sd8711, 16'd2868};

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= Limit) begin
      $display("baro_sensor_compensation_core regression: fail");
      $finish;
    end
  end

  // output stall pattern
  initial begin
    int n;
    forever begin
      @(posedge clk);
      n = sink_stall_on ? $urandom_range(0, 17) : 0;
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n > 0) begin
        m_tready <= 0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [63:0] v);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= bsc_pkg::AddrW'(idx) << 3; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic load_cal(input logic [63:0] a, b, input logic [31:0] m, input logic [1:0] o);
    reg_write(bsc_pkg::REG_CAL_A, a);
    reg_write(bsc_pkg::REG_CAL_B, b);
    reg_write(bsc_pkg::REG_CAL_M, m);
    reg_write(bsc_pkg::REG_OSS, {62'd0, o});
  endtask

  task automatic send(input logic [15:0] ut, input logic [18:0] up, input bit gaps);
    int g;
    g = gaps ? $urandom_range(0, 17) : 0;
    if (gaps && $urandom_range(0, 2) == 0) g = 0;
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {5'd0, up, ut};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    logic [15:0] ut;
    logic [18:0] up;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // zero calibration: zero temperature divisor
    send(16'd27898, 19'd23843, 0);
    drain();

    load_cal(NomA, NomB, NomM, 2'd0);
    send(16'd27898, 19'd23843, 0);
    send(16'd0, 19'd0, 0);
    send(16'hFFFF, 19'h7FFFF, 0);
    send(16'h8000, 19'h40000, 0);
    send(16'd23153, 19'd100, 0);
    drain();
    // zero temperature divisor with nominal set: ut = ac6 gives x1 = 0, md = 0
    load_cal(NomA, NomB, {NomM[31:16], 16'd0}, 2'd3);
    send(16'd23153, 19'd50000, 0);
    send(16'd30000, 19'd50000, 0);
    drain();
    // zero pressure divisor: ac4 = 0
    load_cal({NomA[63:16], 16'd0}, NomB, NomM, 2'd1);
    send(16'd27898, 19'd23843, 0);
    drain();
    // extreme calibration words
    load_cal('1, '1, '1, 2'd3);
    send(16'hFFFF, 19'h7FFFF, 0);
    send(16'd0, 19'd0, 0);
    drain();
    load_cal({4{16'h8000}}, {4{16'h8000}}, {2{16'h8000}}, 2'd2);
    send(16'h1234, 19'h5A5A5, 0);
    send(16'hFFFF, 19'd0, 0);
    drain();

    for (int ph = 0; ph < 13; ph++) begin
      case (ph % 4)
        0: load_cal(NomA, NomB, NomM, 2'(ph));
        1: load_cal(rnd64(), rnd64(), $urandom(), 2'($urandom_range(0, 3)));
        2: load_cal(NomA ^ {4{16'($urandom_range(0, 255))}},
                    NomB ^ {4{16'($urandom_range(0, 255))}},
                    NomM ^ {2{16'($urandom_range(0, 255))}}, 2'($urandom_range(0, 3)));
        default: load_cal(rnd64(), {NomB[63:32], $urandom()}, NomM, 2'd3);
      endcase
      sink_stall_on = (ph % 3 != 2);
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(0, 1)) begin
          ut = 16'($urandom_range(20000, 36000));
          up = 19'($urandom_range(10000, 400000));
        end else begin
          ut = 16'($urandom());
          up = 19'($urandom());
        end
        send(ut, up, ph % 3 != 1);
      end
      drain();
    end

    if (errors == 0) begin
      $display("baro_sensor_compensation_core regression: pass");
    end else begin
      $display("baro_sensor_compensation_core regression: fail");
    end
    $finish;
  end
endmodule
